/* hw/rtl/log_polar_coordinate_map_unit_defines.svh */
// Assertion helpers for the log-polar coordinate map.
// Both expect clk and rst_n in the scope where they are used.
`ifndef LOG_POLAR_COORDINATE_MAP_UNIT_DEFINES_SVH
`define LOG_POLAR_COORDINATE_MAP_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LPM_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define LPM_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/lpm_pkg.sv */
package lpm_pkg;

  localparam int FRAC_BITS    = 16;
  localparam int SINE_ENTRIES = 1024;
  localparam int SINE_W       = FRAC_BITS + 1;
  localparam int IDX_W        = $clog2(SINE_ENTRIES + 1);
  localparam int RING_W       = 11;
  localparam int ANGLE_W      = 12;
  localparam int STEP_W       = 16;
  localparam int DIM_W        = 13;
  localparam int BASE_W       = 27;
  localparam int CFG_DATA_W   = 27;
  localparam int CFG_IDX_W    = 3;
  localparam int COORD_OUT_W  = 12;
  localparam int ADDR_W       = 24;
  // Radius is Q.F and saturates at 16384.0, so it needs 14 + F + 1 bits.
  localparam int RAD_W        = 14 + FRAC_BITS + 1;
  localparam int EXP_W        = RING_W;
  localparam int POW_STAGES   = EXP_W;
  localparam int PROD_W       = RAD_W + SINE_W;
  localparam int COORD_W      = 18;

  localparam logic [RAD_W-1:0] RAD_CAP = {1'b1, {(RAD_W-1){1'b0}}};
  localparam logic [RAD_W-1:0] ONE_Q   = RAD_W'(1) << FRAC_BITS;
  localparam logic [63:0] HALF_PI_Q30  = 64'd1686629713;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INPUT_WIDTH  = 3'd0,
    CFG_INPUT_HEIGHT = 3'd1,
    CFG_FOVEA_RADIUS = 3'd2,
    CFG_EXP_BASE     = 3'd3,
    CFG_ANGLE_STEP   = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [DIM_W-1:0]  input_width;
    logic [DIM_W-1:0]  input_height;
    logic [RING_W-1:0] fovea_radius;
    logic [BASE_W-1:0] exp_base;
    logic [STEP_W-1:0] angle_step;
  } cfg_t;

  typedef struct packed {
    logic              neg;
    logic [IDX_W-1:0]  idx;
  } trig_idx_t;

  typedef struct packed {
    logic              linear;
    logic [RING_W-1:0] ring;
    logic [SINE_W-1:0] sin_mag;
    logic              sin_neg;
    logic [SINE_W-1:0] cos_mag;
    logic              cos_neg;
  } side_t;

  typedef struct packed {
    logic [RAD_W-1:0] acc;
    logic [RAD_W-1:0] base;
    logic [EXP_W-1:0] e;
  } pow_t;

  typedef struct packed {
    logic [COORD_OUT_W-1:0] x_coord;
    logic [COORD_OUT_W-1:0] y_coord;
    logic [ADDR_W-1:0]      pixel_address;
    logic                   out_of_range;
  } result_t;

  typedef logic [SINE_W-1:0] sine_rom_t [SINE_ENTRIES+1];

  // Rounded Q.F product, saturating at the radius cap.
  function automatic logic [RAD_W-1:0] qmul(input logic [RAD_W-1:0] a,
                                            input logic [RAD_W-1:0] b);
    logic [2*RAD_W-1:0] p;
    logic [2*RAD_W-1:0] r;
    logic [RAD_W-1:0]   res;
    p = (2*RAD_W)'(a) * (2*RAD_W)'(b);
    r = (p + ((2*RAD_W)'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
    if (p > ((2*RAD_W)'(1) << (14 + 2*FRAC_BITS))) begin
      res = RAD_CAP;
    end else if (r > (2*RAD_W)'(RAD_CAP)) begin
      res = RAD_CAP;
    end else begin
      res = RAD_W'(r);
    end
    return res;
  endfunction

  // Table entry and sign for a 16-bit phase, quarter-wave folded.
  function automatic trig_idx_t sine_index(input logic [15:0] phase);
    logic [31:0] raw;
    trig_idx_t   res;
    raw = (32'(phase[13:0]) * 32'(SINE_ENTRIES) + 32'd8192) >> 14;
    if (raw > 32'(SINE_ENTRIES)) begin
      raw = 32'(SINE_ENTRIES);
    end
    res.idx = IDX_W'(raw);
    if (phase[14]) begin
      res.idx = IDX_W'(SINE_ENTRIES) - res.idx;
    end
    res.neg = phase[15];
    return res;
  endfunction

  // centre +/- p in Q.2F, rounded half away from zero.
  function automatic logic signed [COORD_W-1:0] place_coord(
      input logic [COORD_OUT_W-1:0] centre,
      input logic [PROD_W-1:0]      p,
      input logic                   neg);
    logic [PROD_W+1:0]           c;
    logic [PROD_W+1:0]           pw;
    logic [PROD_W+1:0]           half;
    logic [PROD_W+1:0]           mag;
    logic signed [COORD_W-1:0]   res;
    c    = (PROD_W+2)'(centre) << (2*FRAC_BITS);
    pw   = (PROD_W+2)'(p);
    half = (PROD_W+2)'(1) << (2*FRAC_BITS - 1);
    if (!neg) begin
      mag = (c + pw + half) >> (2*FRAC_BITS);
      res = COORD_W'(mag);
    end else if (c >= pw) begin
      mag = (c - pw + half) >> (2*FRAC_BITS);
      res = COORD_W'(mag);
    end else begin
      mag = (pw - c + half) >> (2*FRAC_BITS);
      res = -COORD_W'(mag);
    end
    return res;
  endfunction

  function automatic logic [63:0] taylor_div(input logic [63:0] t, input int k);
    logic [63:0] res;
    unique case (k)
      1:       res = (t + 64'd3) / 64'd6;
      2:       res = (t + 64'd10) / 64'd20;
      3:       res = (t + 64'd21) / 64'd42;
      4:       res = (t + 64'd36) / 64'd72;
      5:       res = (t + 64'd55) / 64'd110;
      6:       res = (t + 64'd78) / 64'd156;
      7:       res = (t + 64'd105) / 64'd210;
      8:       res = (t + 64'd136) / 64'd272;
      default: res = t;
    endcase
    return res;
  endfunction

  // Quarter-wave sine table, Q30 Taylor series to x^17, rounded to Q.F.
  function automatic sine_rom_t build_sine_rom();
    sine_rom_t   rom;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    longint      s;
    for (int i = 0; i <= SINE_ENTRIES; i++) begin
      x  = (HALF_PI_Q30 * 64'(i) + 64'(SINE_ENTRIES / 2)) / SINE_ENTRIES;
      x2 = (x * x + (64'd1 << 29)) >> 30;
      t  = x;
      s  = longint'(x);
      for (int k = 1; k <= 8; k++) begin
        t = (t * x2 + (64'd1 << 29)) >> 30;
        t = taylor_div(t, k);
        if ((k & 1) != 0) begin
          s = s - longint'(t);
        end else begin
          s = s + longint'(t);
        end
      end
      if (s < 0) begin
        s = 0;
      end
      rom[i] = SINE_W'((64'(s) + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS));
    end
    return rom;
  endfunction

endpackage

/* hw/rtl/lpm_in_if.sv */
interface lpm_in_if;
  logic        valid;
  logic        ready;
  logic [10:0] ring_index;
  logic [11:0] angle_index;

  modport source (output valid, output ring_index, output angle_index, input ready);
  modport sink (input valid, input ring_index, input angle_index, output ready);
endinterface

/* hw/rtl/lpm_out_if.sv */
interface lpm_out_if;
  logic        valid;
  logic        ready;
  logic [11:0] x_coord;
  logic [11:0] y_coord;
  logic [23:0] pixel_address;
  logic        out_of_range;

  modport source (output valid, output x_coord, output y_coord, output pixel_address,
                  output out_of_range, input ready);
  modport sink (input valid, input x_coord, input y_coord, input pixel_address,
                input out_of_range, output ready);
endinterface

/* hw/rtl/lpm_front.sv */
module lpm_front
  import lpm_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_valid,
  input  logic [RING_W-1:0]  ring_index,
  input  logic [ANGLE_W-1:0] angle_index,
  input  cfg_t               cfg,
  output logic               out_valid,
  output side_t              out_side,
  output pow_t               out_pow
);

  localparam sine_rom_t SINE_ROM = build_sine_rom();

  logic [ANGLE_W+STEP_W-1:0] phase_prod;
  logic [15:0]               phase;
  logic [15:0]               cos_phase;

  logic              a_valid_r;
  logic              a_linear_r;
  logic [RING_W-1:0] a_ring_r;
  logic [EXP_W-1:0]  a_e_r;
  trig_idx_t         a_sin_r;
  trig_idx_t         a_cos_r;

  logic              b_valid_r;
  logic              b_linear_r;
  logic [RING_W-1:0] b_ring_r;
  logic [EXP_W-1:0]  b_e_r;
  logic              b_sin_neg_r;
  logic              b_cos_neg_r;
  logic [SINE_W-1:0] b_sin_mag_r;
  logic [SINE_W-1:0] b_cos_mag_r;

  always_comb begin
    phase_prod = (ANGLE_W+STEP_W)'(angle_index) * (ANGLE_W+STEP_W)'(cfg.angle_step);
    phase      = phase_prod[15:0];
    cos_phase  = phase + 16'h4000;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
    end else if (en) begin
      a_valid_r <= in_valid;
      b_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_linear_r <= (ring_index <= cfg.fovea_radius);
      a_ring_r   <= ring_index;
      a_e_r      <= (ring_index <= cfg.fovea_radius) ? '0 : ring_index - cfg.fovea_radius;
      a_sin_r    <= sine_index(phase);
      a_cos_r    <= sine_index(cos_phase);

      b_linear_r  <= a_linear_r;
      b_ring_r    <= a_ring_r;
      b_e_r       <= a_e_r;
      b_sin_neg_r <= a_sin_r.neg;
      b_cos_neg_r <= a_cos_r.neg;
    end
  end

  // Two read ports into the sine ROM, one for sine and one for cosine.
  always_ff @(posedge clk) begin
    if (en) begin
      b_sin_mag_r <= SINE_ROM[a_sin_r.idx];
      b_cos_mag_r <= SINE_ROM[a_cos_r.idx];
    end
  end

  always_comb begin
    out_valid        = b_valid_r;
    out_side.linear  = b_linear_r;
    out_side.ring    = b_ring_r;
    out_side.sin_mag = b_sin_mag_r;
    out_side.sin_neg = b_sin_neg_r;
    out_side.cos_mag = b_cos_mag_r;
    out_side.cos_neg = b_cos_neg_r;
    out_pow.acc      = ONE_Q;
    out_pow.base     = RAD_W'(cfg.exp_base);
    out_pow.e        = b_e_r;
  end

endmodule

/* hw/rtl/lpm_pow_stage.sv */
module lpm_pow_stage
  import lpm_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  en,
  input  logic  in_valid,
  input  side_t in_side,
  input  pow_t  in_pow,
  output logic  out_valid,
  output side_t out_side,
  output pow_t  out_pow
);

  logic  valid_r;
  side_t side_r;
  pow_t  pow_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  // One bit of the exponent per stage: multiply in the current power, then square it.
  always_ff @(posedge clk) begin
    if (en) begin
      side_r     <= in_side;
      pow_r.acc  <= in_pow.e[0] ? qmul(in_pow.acc, in_pow.base) : in_pow.acc;
      pow_r.base <= qmul(in_pow.base, in_pow.base);
      pow_r.e    <= in_pow.e >> 1;
    end
  end

  assign out_valid = valid_r;
  assign out_side  = side_r;
  assign out_pow   = pow_r;

endmodule

/* hw/rtl/lpm_place.sv */
module lpm_place
  import lpm_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    en,
  input  logic    in_valid,
  input  side_t   in_side,
  input  pow_t    in_pow,
  input  cfg_t    cfg,
  output logic    out_valid,
  output result_t out_result
);

  logic [RAD_W:0]   outer_sum;
  logic [RAD_W-1:0] rad_nxt;
  logic             x_in;
  logic             y_in;

  logic [3:0]       valid_r;
  logic [RAD_W-1:0] rad_r;
  side_t            side_r;
  logic [PROD_W-1:0] prod_x_r;
  logic [PROD_W-1:0] prod_y_r;
  logic             cos_neg_r;
  logic             sin_neg_r;
  logic signed [COORD_W-1:0] x_r;
  logic signed [COORD_W-1:0] y_r;
  result_t          result_r;

  always_comb begin
    outer_sum = (RAD_W+1)'({cfg.fovea_radius, {FRAC_BITS{1'b0}}}) + (RAD_W+1)'(in_pow.acc);
    if (in_side.linear) begin
      rad_nxt = RAD_W'({in_side.ring, {FRAC_BITS{1'b0}}});
    end else if (outer_sum > (RAD_W+1)'(RAD_CAP)) begin
      rad_nxt = RAD_CAP;
    end else begin
      rad_nxt = RAD_W'(outer_sum);
    end
  end

  always_comb begin
    x_in = !x_r[COORD_W-1] && (x_r[COORD_W-2:0] < (COORD_W-1)'(cfg.input_width));
    y_in = !y_r[COORD_W-1] && (y_r[COORD_W-2:0] < (COORD_W-1)'(cfg.input_height));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (en) begin
      valid_r <= {valid_r[2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad_r  <= rad_nxt;
      side_r <= in_side;

      prod_x_r  <= PROD_W'(rad_r) * PROD_W'(side_r.cos_mag);
      prod_y_r  <= PROD_W'(rad_r) * PROD_W'(side_r.sin_mag);
      cos_neg_r <= side_r.cos_neg;
      sin_neg_r <= side_r.sin_neg;

      x_r <= place_coord(cfg.input_width[DIM_W-1:1], prod_x_r, cos_neg_r);
      y_r <= place_coord(cfg.input_height[DIM_W-1:1], prod_y_r, sin_neg_r);

      if (x_in && y_in) begin
        result_r.x_coord       <= x_r[COORD_OUT_W-1:0];
        result_r.y_coord       <= y_r[COORD_OUT_W-1:0];
        result_r.pixel_address <= ADDR_W'((2*DIM_W)'(y_r[DIM_W-1:0])
                                  * (2*DIM_W)'(cfg.input_width)
                                  + (2*DIM_W)'(x_r[DIM_W-1:0]));
        result_r.out_of_range  <= 1'b0;
      end else begin
        result_r.x_coord       <= '0;
        result_r.y_coord       <= '0;
        result_r.pixel_address <= '0;
        result_r.out_of_range  <= 1'b1;
      end
    end
  end

  assign out_valid  = valid_r[3];
  assign out_result = result_r;

endmodule

/* hw/rtl/lpm_out_buf.sv */
module lpm_out_buf
  import lpm_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  input  result_t in_result,
  output logic    en,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_result
);

  logic    out_valid_r;
  logic    skid_valid_r;
  result_t out_data_r;
  result_t skid_data_r;

  // The pipeline only freezes while the skid entry holds a request.
  assign en = !skid_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_ready) begin
        skid_valid_r <= 1'b0;
      end
    end else if (in_valid) begin
      if (!out_valid_r || out_ready) begin
        out_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_ready) begin
        out_data_r <= skid_data_r;
      end
    end else if (in_valid) begin
      if (!out_valid_r || out_ready) begin
        out_data_r <= in_result;
      end else begin
        skid_data_r <= in_result;
      end
    end
  end

  assign out_valid  = out_valid_r;
  assign out_result = out_data_r;

endmodule

/* hw/rtl/log_polar_coordinate_map_unit.sv */
// Maps a log-polar pixel (ring, angle) to the input image pixel it samples, one request
// per clock while the skid entry is empty. The pipeline is 17 register stages deep plus
// an output register. The depth comes from the outer-ring power: one stage per exponent
// bit (eleven), each with its own pair of 31x31 multipliers, ahead of the radius, the
// trig products, the rounding and the range check with the address multiply. Sine and
// cosine come from a 1025-entry quarter-wave ROM read through two ports. A skid entry at
// the output lets the block keep taking requests while one result waits. The user must
// write configuration registers only while no request is in flight; the block itself
// does not enforce this.
`include "log_polar_coordinate_map_unit_defines.svh"

module log_polar_coordinate_map_unit
  import lpm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  lpm_in_if.sink                in_ch,
  lpm_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t    cfg_r;
  logic    en;
  logic    front_valid;
  side_t   front_side;
  pow_t    front_pow;
  logic    place_valid;
  result_t place_result;
  result_t out_result;

  logic [POW_STAGES:0] pv;
  side_t               ps [POW_STAGES+1];
  pow_t                pp [POW_STAGES+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.input_width  <= DIM_W'(320);
      cfg_r.input_height <= DIM_W'(240);
      cfg_r.fovea_radius <= RING_W'(10);
      cfg_r.exp_base     <= BASE_W'(68813);
      cfg_r.angle_step   <= STEP_W'(1024);
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_INPUT_WIDTH:  cfg_r.input_width  <= cfg_wdata[DIM_W-1:0];
        CFG_INPUT_HEIGHT: cfg_r.input_height <= cfg_wdata[DIM_W-1:0];
        CFG_FOVEA_RADIUS: cfg_r.fovea_radius <= cfg_wdata[RING_W-1:0];
        CFG_EXP_BASE:     cfg_r.exp_base     <= cfg_wdata[BASE_W-1:0];
        CFG_ANGLE_STEP:   cfg_r.angle_step   <= cfg_wdata[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_ch.ready = en;

  lpm_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .in_valid    (in_ch.valid),
    .ring_index  (in_ch.ring_index),
    .angle_index (in_ch.angle_index),
    .cfg         (cfg_r),
    .out_valid   (front_valid),
    .out_side    (front_side),
    .out_pow     (front_pow)
  );

  assign pv[0] = front_valid;
  assign ps[0] = front_side;
  assign pp[0] = front_pow;

  for (genvar g = 0; g < POW_STAGES; g++) begin : g_pow
    lpm_pow_stage u_stage (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .in_valid  (pv[g]),
      .in_side   (ps[g]),
      .in_pow    (pp[g]),
      .out_valid (pv[g+1]),
      .out_side  (ps[g+1]),
      .out_pow   (pp[g+1])
    );
  end

  lpm_place u_place (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .in_valid   (pv[POW_STAGES]),
    .in_side    (ps[POW_STAGES]),
    .in_pow     (pp[POW_STAGES]),
    .cfg        (cfg_r),
    .out_valid  (place_valid),
    .out_result (place_result)
  );

  lpm_out_buf u_out_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (place_valid),
    .in_result  (place_result),
    .en         (en),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_result (out_result)
  );

  assign out_ch.x_coord       = out_result.x_coord;
  assign out_ch.y_coord       = out_result.y_coord;
  assign out_ch.pixel_address = out_result.pixel_address;
  assign out_ch.out_of_range  = out_result.out_of_range;

  `LPM_ASSERT_IMP(a_stall_has_result, !en, out_ch.valid, "pipeline frozen without a result")
  `LPM_ASSERT_NXT(a_skid_drains, out_ch.valid && out_ch.ready && !en, out_ch.valid, "skid request lost")
  `LPM_ASSERT_IMP(a_oor_zero, out_ch.valid && out_ch.out_of_range, out_ch.x_coord == '0 && out_ch.y_coord == '0 && out_ch.pixel_address == '0, "out-of-range result not cleared")
  `LPM_ASSERT_IMP(a_x_inside, out_ch.valid && !out_ch.out_of_range, DIM_W'(out_ch.x_coord) < cfg_r.input_width, "column beyond image width")

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import lpm_pkg::*;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  lpm_in_if  in_ch ();
  lpm_out_if out_ch ();

  log_polar_coordinate_map_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch.sink),
    .out_ch    (out_ch.source),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Predictor copies of the register file.
  logic [12:0] img_width;
  logic [12:0] img_height;
  logic [10:0] fovea;
  logic [26:0] growth_base;
  logic [15:0] phase_step;

  logic [63:0] quarter_sine [0:1024];
  result_t     pending_coords [$];
  int          fail_count;
  int          burst_left;
  int          stall_cycles;
  longint      cycle_count;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Q30 Taylor series of sin over a quarter turn, rounded to Q16.
  function automatic void fill_quarter_sine();
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] d;
    longint      s;
    for (int i = 0; i <= 1024; i++) begin
      x  = (64'd1686629713 * 64'(i) + 64'd512) / 64'd1024;
      x2 = (x * x + (64'd1 << 29)) >> 30;
      t  = x;
      s  = longint'(x);
      for (int k = 1; k <= 8; k++) begin
        d = 64'((2 * k) * (2 * k + 1));
        t = (t * x2 + (64'd1 << 29)) >> 30;
        t = (t + d / 2) / d;
        if (k % 2 == 1) begin
          s = s - longint'(t);
        end else begin
          s = s + longint'(t);
        end
      end
      if (s < 0) begin
        s = 0;
      end
      quarter_sine[i] = (64'(s) + (64'd1 << 13)) >> 14;
    end
  endfunction

  // Rounded Q16 product, saturating at 16384.0.
  function automatic logic [63:0] fix_mul(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] cap;
    logic [63:0] r;
    cap = 64'd16384 << 16;
    if (a == 0 || b == 0) begin
      return 64'd0;
    end
    if (a > (cap << 16) / b) begin
      return cap;
    end
    r = (a * b + 64'd32768) >> 16;
    return (r > cap) ? cap : r;
  endfunction

  function automatic logic [63:0] sine_mag(input logic [15:0] ph, output logic neg);
    logic [63:0] idx;
    idx = (64'(ph[13:0]) * 64'd1024 + 64'd8192) >> 14;
    if (idx > 64'd1024) begin
      idx = 64'd1024;
    end
    if (ph[14]) begin
      idx = 64'd1024 - idx;
    end
    neg = ph[15];
    return quarter_sine[idx];
  endfunction

  function automatic longint round_coord(input logic [63:0] centre, input logic [63:0] radius,
                                         input logic [63:0] trig, input logic neg);
    logic [63:0] c;
    logic [63:0] p;
    logic [63:0] half;
    c    = centre << 32;
    p    = radius * trig;
    half = 64'd1 << 31;
    if (!neg) begin
      return longint'((c + p + half) >> 32);
    end
    if (c >= p) begin
      return longint'((c - p + half) >> 32);
    end
    return -longint'((p - c + half) >> 32);
  endfunction

  function automatic result_t map_pixel(input logic [10:0] ring, input logic [11:0] angle);
    logic [63:0] e;
    logic [63:0] acc;
    logic [63:0] b;
    logic [63:0] radius;
    logic [63:0] s_mag;
    logic [63:0] c_mag;
    logic [63:0] addr;
    logic [15:0] phase;
    logic        s_neg;
    logic        c_neg;
    longint      x;
    longint      y;
    result_t     r;
    if (ring <= fovea) begin
      radius = 64'(ring) << 16;
    end else begin
      e   = 64'(ring - fovea);
      acc = 64'd1 << 16;
      b   = (64'(growth_base) > (64'd16384 << 16)) ? (64'd16384 << 16) : 64'(growth_base);
      while (e != 0) begin
        if (e[0]) begin
          acc = fix_mul(acc, b);
        end
        e = e >> 1;
        if (e != 0) begin
          b = fix_mul(b, b);
        end
      end
      radius = (64'(fovea) << 16) + acc;
      if (radius > (64'd16384 << 16)) begin
        radius = 64'd16384 << 16;
      end
    end
    phase = 16'(32'(angle) * 32'(phase_step));
    s_mag = sine_mag(phase, s_neg);
    c_mag = sine_mag(phase + 16'd16384, c_neg);
    x = round_coord(64'(img_width >> 1), radius, c_mag, c_neg);
    y = round_coord(64'(img_height >> 1), radius, s_mag, s_neg);
    r = '0;
    if (x < 0 || y < 0 || x >= longint'(img_width) || y >= longint'(img_height)) begin
      r.out_of_range = 1'b1;
    end else begin
      addr = 64'(y) * 64'(img_width) + 64'(x);
      r.x_coord       = 12'(x);
      r.y_coord       = 12'(y);
      r.pixel_address = 24'(addr);
    end
    return r;
  endfunction

  // Sends one request in bursts separated by random gaps; valid stays high between
  // back-to-back requests.
  task automatic send_request(input logic [10:0] ring, input logic [11:0] angle);
    if (burst_left == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                : $urandom_range(1, 12);
    end
    burst_left--;
    in_ch.valid       <= 1'b1;
    in_ch.ring_index  <= ring;
    in_ch.angle_index <= angle;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pending_coords = {pending_coords, map_pixel(ring, angle)};
  endtask

  task automatic drain_pipeline();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_coords.size() != 0) @(posedge clk);
    repeat (25) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [26:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_INPUT_WIDTH:  img_width   = value[12:0];
      CFG_INPUT_HEIGHT: img_height  = value[12:0];
      CFG_FOVEA_RADIUS: fovea       = value[10:0];
      CFG_EXP_BASE:     growth_base = value;
      CFG_ANGLE_STEP:   phase_step  = value[15:0];
      default: ;
    endcase
  endtask

  task automatic load_config(input logic [12:0] w, input logic [12:0] h, input logic [10:0] f,
                             input logic [26:0] b, input logic [15:0] st);
    drain_pipeline();
    write_reg(CFG_INPUT_WIDTH, 27'(w));
    write_reg(CFG_INPUT_HEIGHT, 27'(h));
    write_reg(CFG_FOVEA_RADIUS, 27'(f));
    write_reg(CFG_EXP_BASE, b);
    write_reg(CFG_ANGLE_STEP, 27'(st));
  endtask

  task automatic test_reset_defaults();
    send_request(11'd0, 12'd0);
    send_request(11'd2047, 12'd4095);
    send_request(11'd10, 12'd16);
    send_request(11'd11, 12'd32);
    send_request(11'd5, 12'd48);
    send_request(11'd30, 12'd0);
    send_request(11'd100, 12'd8);
  endtask

  // Quadrant edges, the linear/outer boundary and the fully saturated radius.
  task automatic test_extremes();
    load_config(13'd4096, 13'd4096, 11'd0, 27'd65536, 16'd1);
    send_request(11'd0, 12'd0);
    send_request(11'd2047, 12'd0);
    send_request(11'd1, 12'd4095);
    drain_pipeline();
    write_reg(CFG_ANGLE_STEP, 27'd16384);
    for (int q = 0; q < 4; q++) begin
      send_request(11'd1000, 12'(q));
    end
    load_config(13'd8191, 13'd8191, 11'd2047, 27'h7FFFFFF, 16'd65535);
    send_request(11'd2047, 12'd4095);
    send_request(11'd2047, 12'd1);
    send_request(11'd1500, 12'd2048);
    load_config(13'd2, 13'd2, 11'd3, 27'd0, 16'd8);
    send_request(11'd0, 12'd0);
    send_request(11'd4, 12'd0);
    send_request(11'd2047, 12'd7);
    load_config(13'd0, 13'd0, 11'd0, 27'd131072, 16'd0);
    send_request(11'd0, 12'd0);
    send_request(11'd12, 12'd99);
  endtask

  task automatic test_random_sweeps();
    logic [10:0] ring;
    for (int phase_no = 0; phase_no < 12; phase_no++) begin
      if (phase_no % 4 == 0) begin
        load_config(13'($urandom_range(0, 8191)), 13'($urandom_range(0, 8191)),
                    11'($urandom_range(0, 2047)), 27'($urandom),
                    16'($urandom));
      end else begin
        load_config(13'($urandom_range(2, 4096)), 13'($urandom_range(2, 4096)),
                    11'($urandom_range(0, 60)), 27'($urandom_range(65536, 72000)),
                    16'($urandom_range(1, 65535)));
      end
      for (int n = 0; n < 155; n++) begin
        case ($urandom_range(0, 3))
          0: ring = 11'($urandom);
          1: ring = 11'($urandom_range(0, fovea + 1));
          default: ring = 11'(fovea + $urandom_range(0, 80));
        endcase
        send_request(ring, 12'($urandom));
      end
    end
  endtask

  // Receiver stall pattern steps through four modes selected from the cycle counter.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    case ((cycle_count >> 9) % 4)
      0: out_ch.ready <= 1'b1;
      1: out_ch.ready <= $urandom_range(0, 1);
      2: out_ch.ready <= ($urandom_range(0, 3) == 0);
      default: out_ch.ready <= (cycle_count % 16) < 10;
    endcase
  end

  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_coords.size() == 0) begin
        $error("result with no request outstanding");
        fail_count++;
      end else begin
        want = pending_coords.pop_front();
        if (out_ch.x_coord !== want.x_coord) begin
          $error("x_coord expected %0d actual %0d", want.x_coord, out_ch.x_coord);
          fail_count++;
        end
        if (out_ch.y_coord !== want.y_coord) begin
          $error("y_coord expected %0d actual %0d", want.y_coord, out_ch.y_coord);
          fail_count++;
        end
        if (out_ch.pixel_address !== want.pixel_address) begin
          $error("pixel_address expected %0d actual %0d", want.pixel_address,
                 out_ch.pixel_address);
          fail_count++;
        end
        if (out_ch.out_of_range !== want.out_of_range) begin
          $error("out_of_range expected %0d actual %0d", want.out_of_range,
                 out_ch.out_of_range);
          fail_count++;
        end
      end
    end
  end

  // Counts cycles with work outstanding and nothing moving on either channel.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (!in_ch.valid && pending_coords.size() == 0)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= 5000) begin
      $display("log_polar_coordinate_map_unit: mismatch");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = '0;
    cfg_wdata         = '0;
    in_ch.valid       = 1'b0;
    in_ch.ring_index  = '0;
    in_ch.angle_index = '0;
    out_ch.ready      = 1'b0;
    cycle_count       = 0;
    stall_cycles      = 0;
    fail_count        = 0;
    burst_left        = 0;
    img_width         = 13'd320;
    img_height        = 13'd240;
    fovea             = 11'd10;
    growth_base       = 27'd68813;
    phase_step        = 16'd1024;
    fill_quarter_sine();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_extremes();
    test_random_sweeps();
    drain_pipeline();
    if (fail_count == 0) begin
      $display("log_polar_coordinate_map_unit: match");
    end else begin
      $display("log_polar_coordinate_map_unit: mismatch");
    end
    $finish;
  end

endmodule

/* log_polar_coordinate_map_unit.f */
+incdir+hw/rtl
hw/rtl/lpm_pkg.sv
hw/rtl/lpm_in_if.sv
hw/rtl/lpm_out_if.sv
hw/rtl/lpm_front.sv
hw/rtl/lpm_pow_stage.sv
hw/rtl/lpm_place.sv
hw/rtl/lpm_out_buf.sv
hw/rtl/log_polar_coordinate_map_unit.sv
test/testbench.sv
